### rtl/ptt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg: shared codes and types for the priority timer table
// Function and result codes, walk modes, and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam logic [1:0] FUNC_REGISTER = 2'd0;
  localparam logic [1:0] FUNC_CANCEL   = 2'd1;
  localparam logic [1:0] FUNC_TICK     = 2'd2;

  localparam logic [1:0] KIND_REGISTERED = 2'd0;
  localparam logic [1:0] KIND_CANCELED   = 2'd1;
  localparam logic [1:0] KIND_EXPIRED    = 2'd2;
  localparam logic [1:0] KIND_FULL       = 2'd3;

  localparam logic [1:0] WALK_DEC = 2'd0;
  localparam logic [1:0] WALK_CAN = 2'd1;
  localparam logic [1:0] WALK_SEL = 2'd2;
  localparam logic [1:0] WALK_CMP = 2'd3;

  localparam logic [15:0] ID_START = 16'd50;

  typedef struct packed {
    logic       capture;
    logic       scan_step;
    logic       insert;
    logic       walk_start;
    logic [1:0] walk_mode;
    logic       free_best;
    logic       out_load;
    logic [1:0] out_kind;
  } ptt_cmd_t;

  typedef struct packed {
    logic full;
    logic free_hit;
    logic walk_done;
    logic best_valid;
    logic exp_any;
    logic out_free;
  } ptt_stat_t;

endpackage
`default_nettype wire

### rtl/ptt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/ptt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_ctrl: sequencing controller for the priority timer table
// Accepts one request word at a time and steps the datapath through its
// slot scans, table walks and result loads.
// ----------------------------------------------------------------------------
module ptt_ctrl import ptt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  input  wire logic [1:0] func,
  output      logic       req_stall,
  input  wire ptt_stat_t  stat,
  output      ptt_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FREE = 3'd1;
  localparam logic [2:0] S_WDEC = 3'd2;
  localparam logic [2:0] S_WCAN = 3'd3;
  localparam logic [2:0] S_WSEL = 3'd4;
  localparam logic [2:0] S_WCMP = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] pend_kind;
  logic [1:0] pend_kind_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    pend_kind_next = pend_kind;
    cmd            = '0;
    cmd.out_kind   = pend_kind;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          case (func)
            FUNC_REGISTER: begin
              if (stat.full) begin
                pend_kind_next = KIND_FULL;
                state_next     = S_OUT;
              end else begin
                state_next = S_FREE;
              end
            end
            FUNC_CANCEL: begin
              cmd.walk_start = 1'b1;
              cmd.walk_mode  = WALK_CAN;
              state_next     = S_WCAN;
            end
            FUNC_TICK: begin
              cmd.walk_start = 1'b1;
              cmd.walk_mode  = WALK_DEC;
              state_next     = S_WDEC;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_FREE: begin
        if (stat.free_hit) begin
          cmd.insert     = 1'b1;
          pend_kind_next = KIND_REGISTERED;
          state_next     = S_OUT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_WCAN: begin
        if (stat.walk_done) begin
          pend_kind_next = KIND_CANCELED;
          if (stat.best_valid) begin
            cmd.free_best  = 1'b1;
            cmd.walk_start = 1'b1;
            cmd.walk_mode  = WALK_CMP;
            state_next     = S_WCMP;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_WDEC: begin
        if (stat.walk_done) begin
          if (stat.exp_any) begin
            cmd.walk_start = 1'b1;
            cmd.walk_mode  = WALK_SEL;
            state_next     = S_WSEL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_WSEL: begin
        if (stat.walk_done) begin
          cmd.free_best  = 1'b1;
          cmd.walk_start = 1'b1;
          cmd.walk_mode  = WALK_CMP;
          pend_kind_next = KIND_EXPIRED;
          state_next     = S_WCMP;
        end
      end
      S_WCMP: begin
        if (stat.walk_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if ((pend_kind == KIND_EXPIRED) && stat.exp_any) begin
            cmd.walk_start = 1'b1;
            cmd.walk_mode  = WALK_SEL;
            state_next     = S_WSEL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend_kind <= KIND_REGISTERED;
    end else begin
      state     <= state_next;
      pend_kind <= pend_kind_next;
    end
  end

endmodule
`default_nettype wire

### rtl/ptt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_dp: datapath of the priority timer table
// Holds the slot memory, live and expired flags, the id counter, the walk
// counter with its read pipeline, the best-candidate registers and the
// result register.
// ----------------------------------------------------------------------------
module ptt_dp import ptt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ptt_cmd_t    cmd,
  output      ptt_stat_t   stat,
  input  wire logic [15:0] seconds,
  input  wire logic [7:0]  priority_req,
  input  wire logic [31:0] client_tag,
  input  wire logic [15:0] cancel_id,
  output      logic        res_valid,
  input  wire logic        res_stall,
  output      logic [1:0]  kind,
  output      logic [15:0] timer_id,
  output      logic [31:0] client_tag_res,
  output      logic        last
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW:0] SLOT_CNT = (IW + 1)'(SLOTS);

  typedef struct packed {
    logic [15:0]   id;
    logic [7:0]    prio;
    logic [15:0]   rem;
    logic [31:0]   client;
    logic [IW-1:0] arr;
  } rec_t;

  logic [15:0]      cap_secs;
  logic [7:0]       cap_prio;
  logic [31:0]      cap_tag;
  logic [15:0]      cap_cid;
  logic [15:0]      id_counter;
  logic [SLOTS-1:0] live;
  logic [SLOTS-1:0] expired;
  logic [IW:0]      live_cnt;
  logic [IW:0]      idx;
  logic             walking;
  logic [1:0]       mode;
  logic             rd_vld;
  logic [IW-1:0]    pidx;
  logic             best_valid;
  logic [IW-1:0]    best_idx;
  logic [15:0]      best_id;
  logic [31:0]      best_client;
  logic [7:0]       best_prio;
  logic [IW-1:0]    best_arr;
  logic [IW-1:0]    cmp_arr;

  rec_t                 r;
  rec_t                 wrec;
  logic [$bits(rec_t)-1:0] ram_rdata;
  logic                 we;
  logic [IW-1:0]        waddr;
  logic                 lv;
  logic                 ex;
  logic                 better;
  logic                 take;

  ptt_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wrec),
    .raddr (idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign r      = rec_t'(ram_rdata);
  assign lv     = live[pidx];
  assign ex     = expired[pidx];
  assign better = !best_valid || (r.prio > best_prio) ||
                  ((r.prio == best_prio) && (r.arr < best_arr));
  assign take   = rd_vld && better &&
                  (((mode == WALK_CAN) && lv && (r.id == cap_cid)) ||
                   ((mode == WALK_SEL) && ex));

  always_comb begin
    we    = 1'b0;
    waddr = pidx;
    wrec  = r;
    if (cmd.insert) begin
      we          = 1'b1;
      waddr       = idx[IW-1:0];
      wrec.id     = id_counter + 16'd1;
      wrec.prio   = cap_prio;
      wrec.rem    = (cap_secs == 16'd0) ? 16'd1 : cap_secs;
      wrec.client = cap_tag;
      wrec.arr    = live_cnt[IW-1:0];
    end else if (rd_vld) begin
      case (mode)
        WALK_DEC: begin
          if (lv) begin
            we       = 1'b1;
            wrec.rem = (r.rem <= 16'd1) ? 16'd0 : (r.rem - 16'd1);
          end
        end
        WALK_CMP: begin
          if (lv && (r.arr > cmp_arr)) begin
            we       = 1'b1;
            wrec.arr = r.arr - IW'(1);
          end
        end
        default: we = 1'b0;
      endcase
    end
  end

  assign stat.full       = (live_cnt == SLOT_CNT);
  assign stat.free_hit   = !live[idx[IW-1:0]];
  assign stat.walk_done  = walking && (idx == SLOT_CNT) && !rd_vld;
  assign stat.best_valid = best_valid;
  assign stat.exp_any    = |expired;
  assign stat.out_free   = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_counter <= ID_START;
      live       <= '0;
      expired    <= '0;
      live_cnt   <= '0;
      idx        <= '0;
      walking    <= 1'b0;
      mode       <= WALK_DEC;
      rd_vld     <= 1'b0;
      best_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      rd_vld <= walking && (idx < SLOT_CNT);
      if (cmd.capture) begin
        idx <= '0;
      end
      if (cmd.scan_step) begin
        idx <= idx + 1'b1;
      end
      if (cmd.insert) begin
        live[idx[IW-1:0]] <= 1'b1;
        live_cnt          <= live_cnt + 1'b1;
        id_counter        <= id_counter + 16'd1;
      end
      if (cmd.walk_start) begin
        walking <= 1'b1;
        idx     <= '0;
        mode    <= cmd.walk_mode;
        if ((cmd.walk_mode == WALK_CAN) || (cmd.walk_mode == WALK_SEL)) begin
          best_valid <= 1'b0;
        end
        if (cmd.walk_mode == WALK_DEC) begin
          expired <= '0;
        end
      end else if (walking) begin
        if (idx < SLOT_CNT) begin
          idx <= idx + 1'b1;
        end else if (!rd_vld) begin
          walking <= 1'b0;
        end
      end
      if (rd_vld && (mode == WALK_DEC) && lv && (r.rem <= 16'd1)) begin
        expired[pidx] <= 1'b1;
      end
      if (take) begin
        best_valid <= 1'b1;
      end
      if (cmd.free_best) begin
        live[best_idx]    <= 1'b0;
        expired[best_idx] <= 1'b0;
        live_cnt          <= live_cnt - 1'b1;
      end
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx <= idx[IW-1:0];
    if (cmd.capture) begin
      cap_secs <= seconds;
      cap_prio <= priority_req;
      cap_tag  <= client_tag;
      cap_cid  <= cancel_id;
    end
    if (take) begin
      best_idx    <= pidx;
      best_id     <= r.id;
      best_client <= r.client;
      best_prio   <= r.prio;
      best_arr    <= r.arr;
    end
    if (cmd.free_best) begin
      cmp_arr <= best_arr;
    end
    if (cmd.out_load) begin
      kind <= cmd.out_kind;
      last <= (cmd.out_kind != KIND_EXPIRED) || (expired == '0);
      case (cmd.out_kind)
        KIND_REGISTERED: begin
          timer_id       <= id_counter;
          client_tag_res <= cap_tag;
        end
        KIND_CANCELED: begin
          timer_id       <= cap_cid;
          client_tag_res <= cap_tag;
        end
        KIND_EXPIRED: begin
          timer_id       <= best_id;
          client_tag_res <= best_client;
        end
        default: begin
          timer_id       <= 16'd0;
          client_tag_res <= cap_tag;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/priority_software_timer_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// priority_software_timer_table: one-shot timer table with priority expiry
// Request words register a timer, cancel a timer or deliver a one-second
// tick. Each register or cancel word gives one result word; a tick gives one
// expired word per timer that runs out, highest priority first and, within
// one priority, oldest first, with last set on the final one.
//
// Both channels use valid and stall. A request word is taken only while the
// block is idle; the result register lets the next request in while a
// result still waits. While the receiver stalls, the result word holds and
// the block waits before loading the next one.
// A register word scans for a free slot unless the table is full. A cancel
// walks the slot memory once, plus a second walk when a timer is removed.
// A tick walks the slot memory once and then, per expired timer, makes one
// walk to pick it and one walk to close the gap in the age ranks, through
// the single memory read port.
// Reset clears all timers and sets the id counter so the first id is 51;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_software_timer_table import ptt_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output      logic        req_stall,
  input  wire logic [1:0]  func,
  input  wire logic [15:0] seconds,
  input  wire logic [7:0]  priority_req,
  input  wire logic [31:0] client_tag,
  input  wire logic [15:0] cancel_id,
  output      logic        res_valid,
  input  wire logic        res_stall,
  output      logic [1:0]  kind,
  output      logic [15:0] timer_id,
  output      logic [31:0] client_tag_res,
  output      logic        last
);

  ptt_cmd_t  cmd;
  ptt_stat_t stat;

  ptt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .func      (func),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .seconds        (seconds),
    .priority_req   (priority_req),
    .client_tag     (client_tag),
    .cancel_id      (cancel_id),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .kind           (kind),
    .timer_id       (timer_id),
    .client_tag_res (client_tag_res),
    .last           (last)
  );

endmodule
`default_nettype wire
